FILE: src/assert_macros.svh
// Assertion macros shared by the RTL of the sample format converter.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check an implication under the active-low reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// check that a condition holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

FILE: src/asfc_pkg.sv
// Types and constants of the audio sample format converter.
// No dependencies.
`timescale 1ns / 1ps

package asfc_pkg;

  localparam int unsigned SampleW = 32;

  typedef enum logic [1:0] {
    FMT_S16 = 2'd0,
    FMT_S32 = 2'd1,
    FMT_F32 = 2'd2,
    FMT_RSV = 2'd3
  } fmt_t;

  typedef struct packed {
    fmt_t src;
    fmt_t dst;
  } cfg_t;

  typedef enum logic {
    REG_SOURCE_FORMAT = 1'b0,
    REG_TARGET_FORMAT = 1'b1
  } reg_idx_t;

  localparam logic [31:0] S16Max = 32'h0000_7FFF;
  localparam logic [31:0] S16Min = 32'hFFFF_8000;
  localparam logic [31:0] S32Max = 32'h7FFF_FFFF;
  localparam logic [31:0] S32Min = 32'h8000_0000;

endpackage

FILE: src/asfc_in_if.sv
// Input sample channel: valid/ready handshake with sample payload.
// Depends on nothing.
`timescale 1ns / 1ps

interface asfc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_bits;
  logic        last_sample;

  modport source (output valid, output sample_bits, output last_sample, input ready);
  modport sink (input valid, input sample_bits, input last_sample, output ready);
endinterface

FILE: src/asfc_out_if.sv
// Result sample channel: valid/ready handshake with result payload.
// Depends on nothing.
`timescale 1ns / 1ps

interface asfc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_bits;
  logic        last_result;

  modport source (output valid, output result_bits, output last_result, input ready);
  modport sink (input valid, input result_bits, input last_result, output ready);
endinterface

FILE: src/asfc_cfg_regs.sv
// APB-style configuration registers: source and target format.
// Depends on asfc_pkg.
`timescale 1ns / 1ps

module asfc_cfg_regs (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output asfc_pkg::cfg_t       cfg
);
  import asfc_pkg::*;

  fmt_t     src_r, src_nxt;
  fmt_t     dst_r, dst_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    src_nxt = src_r;
    dst_nxt = dst_r;
    if (wr_en) begin
      unique case (idx)
        REG_SOURCE_FORMAT: src_nxt = fmt_t'(pwdata[1:0]);
        REG_TARGET_FORMAT: dst_nxt = fmt_t'(pwdata[1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= FMT_S16;
      dst_r <= FMT_S16;
    end else begin
      src_r <= src_nxt;
      dst_r <= dst_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_SOURCE_FORMAT: prdata = {30'd0, src_r};
      REG_TARGET_FORMAT: prdata = {30'd0, dst_r};
      default:           prdata = 32'd0;
    endcase
  end

  assign cfg = '{src: src_r, dst: dst_r};
endmodule

FILE: src/asfc_convert.sv
// Combinational sample conversion between s16, s32 and float32.
// Depends on asfc_pkg.
`timescale 1ns / 1ps

module asfc_convert (
  input  asfc_pkg::cfg_t cfg,
  input  logic [31:0]    x,
  output logic [31:0]    y
);
  import asfc_pkg::*;

  function automatic logic [31:0] sext16(input logic [15:0] v);
    sext16 = {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] s32_to_f32(input logic [31:0] s);
    logic [31:0] mag;
    logic [4:0]  p;
    logic [31:0] norm;
    logic [24:0] mant;
    logic        rnd;
    logic [7:0]  expo;
    mag = s[31] ? (32'd0 - s) : s;
    p   = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) p = 5'(i);
    end
    norm = mag << (5'd31 - p);
    rnd  = norm[7] && ((|norm[6:0]) || norm[8]);
    mant = {1'b0, norm[31:8]} + {24'd0, rnd};
    expo = {3'd0, p} + 8'd96 + {7'd0, mant[24]};
    if (mag == 32'd0) s32_to_f32 = 32'd0;
    else              s32_to_f32 = {s[31], expo, mant[22:0]};
  endfunction

  function automatic logic [31:0] f32_to_s16(input logic [31:0] b);
    logic [7:0]  e;
    logic [23:0] sig;
    logic [15:0] mag;
    logic [4:0]  sh;
    e   = b[30:23];
    sig = {1'b1, b[22:0]};
    sh  = 5'(8'd135 - e);
    mag = 16'(sig >> sh);
    if (e == 8'hFF && b[22:0] != 23'd0) f32_to_s16 = 32'd0;
    else if (e >= 8'd127)               f32_to_s16 = b[31] ? S16Min : S16Max;
    else if (e < 8'd112)                f32_to_s16 = 32'd0;
    else f32_to_s16 = b[31] ? (32'd0 - {16'd0, mag}) : {16'd0, mag};
  endfunction

  function automatic logic [31:0] f32_to_s32(input logic [31:0] b);
    logic [7:0]  e;
    logic [4:0]  k;
    logic [53:0] wide;
    logic [31:0] mag;
    e    = b[30:23];
    k    = 5'(e - 8'd96);
    wide = {30'd0, 1'b1, b[22:0]} << k;
    mag  = 32'(wide >> 23);
    if (e == 8'hFF && b[22:0] != 23'd0) f32_to_s32 = 32'd0;
    else if (e >= 8'd127)               f32_to_s32 = b[31] ? S32Min : S32Max;
    else if (e < 8'd96)                 f32_to_s32 = 32'd0;
    else f32_to_s32 = b[31] ? (32'd0 - mag) : mag;
  endfunction

  always_comb begin
    if (cfg.src == cfg.dst) begin
      y = (cfg.src == FMT_S16) ? sext16(x[15:0]) : x;
    end else begin
      priority if (cfg.src == FMT_S16 && cfg.dst == FMT_S32) y = {x[15:0], 16'd0};
      else if (cfg.src == FMT_S32 && cfg.dst == FMT_S16) y = sext16(x[31:16]);
      else if (cfg.src == FMT_S16 && cfg.dst == FMT_F32) y = s32_to_f32({x[15:0], 16'd0});
      else if (cfg.src == FMT_S32 && cfg.dst == FMT_F32) y = s32_to_f32(x);
      else if (cfg.src == FMT_F32 && cfg.dst == FMT_S16) y = f32_to_s16(x);
      else if (cfg.src == FMT_F32 && cfg.dst == FMT_S32) y = f32_to_s32(x);
      else y = 32'd0;
    end
  end
endmodule

FILE: src/audio_sample_format_converter_core.sv
// Audio sample format converter: one sample per cycle while the result side
// keeps up, between s16, s32 and float32, with an input register,
// combinational conversion and an output register; a sample moves from the
// input register into the output register once that register is empty or
// being read out. Source and target formats are set over the APB port at
// addresses 0 and 4.
// Depends on asfc_pkg, asfc_in_if, asfc_out_if, asfc_cfg_regs, asfc_convert.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module audio_sample_format_converter_core (
  input  logic        clk,
  input  logic        rst_n,
  asfc_in_if.sink     in_ch,
  asfc_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import asfc_pkg::*;

  cfg_t        cfg;
  logic        s1_valid_r;
  logic [31:0] s1_bits_r;
  logic        s1_last_r;
  logic        s2_valid_r;
  logic [31:0] s2_bits_r;
  logic        s2_last_r;
  logic [31:0] conv;
  logic        s2_adv;
  logic        s1_adv;

  asfc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  asfc_convert u_conv (
    .cfg (cfg),
    .x   (s1_bits_r),
    .y   (conv)
  );

  assign s2_adv      = !s2_valid_r || out_ch.ready;
  assign s1_adv      = !s1_valid_r || s2_adv;
  assign in_ch.ready = s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_adv) s1_valid_r <= in_ch.valid;
      if (s2_adv) s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_bits_r <= in_ch.sample_bits;
      s1_last_r <= in_ch.last_sample;
    end
    if (s2_adv) begin
      s2_bits_r <= conv;
      s2_last_r <= s1_last_r;
    end
  end

  assign out_ch.valid       = s2_valid_r;
  assign out_ch.result_bits = s2_bits_r;
  assign out_ch.last_result = s2_last_r;

  `ASSERT_NEXT(a_in_lands, clk, rst_n, in_ch.valid && in_ch.ready, s1_valid_r)
  `ASSERT_NEXT(a_s1_moves, clk, rst_n, s1_valid_r && s2_adv, s2_valid_r)
  `ASSERT_IMPL(a_ready_free, clk, rst_n, !s1_valid_r, in_ch.ready)
endmodule
